@@ src/ssa_pkg.sv @@
// Shared types and constants of the server slot allocator.
package ssa_pkg;

	// Fixed reset values of the configuration registers.
	localparam logic [7:0]  RST_CODE_STOPPED = 8'd0;
	localparam logic [7:0]  RST_CODE_FREE    = 8'd1;
	localparam logic [7:0]  RST_CODE_BUSY    = 8'd2;
	localparam logic [31:0] RST_TIMEOUT_MS   = 32'd15000;

	// A tick never reports more than this many slots.
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W       = 4;

	typedef enum logic [1:0] {
		CMD_REPORT  = 2'd0,
		CMD_REQUEST = 2'd1,
		CMD_TICK    = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_GRANTED   = 3'd0,
		KIND_REFUSED   = 3'd1,
		KIND_STORED    = 3'd2,
		KIND_IGNORED   = 3'd3,
		KIND_RESTART   = 3'd4,
		KIND_CLEARED   = 3'd5,
		KIND_TICK_IDLE = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		REG_BASE_PORT     = 3'd0,
		REG_DISK_PORT     = 3'd1,
		REG_KEYBOARD_PORT = 3'd2,
		REG_TIMEOUT_MS    = 3'd3,
		REG_CODE_STOPPED  = 3'd4,
		REG_CODE_FREE     = 3'd5,
		REG_CODE_BUSY     = 3'd6
	} cfg_reg_t;

	// One slot of the table as held in memory.
	typedef struct packed {
		logic [7:0]  status;
		logic [31:0] owner;
		logic [31:0] seen;
		logic [31:0] pid;
	} slot_entry_t;

	// One result transaction.
	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  slot;
		logic [15:0] worker_port;
		logic [15:0] second_port;
		logic [15:0] third_port;
		logic        spawned;
		logic [31:0] victim_pid;
		logic        last;
	} result_t;

endpackage

@@ src/ssa_slot_mem.sv @@
// Slot table memory with per-entry valid bits standing in for the reset contents.
module ssa_slot_mem
	import ssa_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int IW    = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              re,
	input  logic [IW-1:0]     raddr,
	input  logic              we,
	input  logic [IW-1:0]     waddr,
	input  slot_entry_t       wdata,
	output slot_entry_t       rdata,
	output logic [IW-1:0]     ridx
);

	slot_entry_t   mem [SLOTS];
	slot_entry_t   raw_s1;
	logic          rvld_s1;
	logic [IW-1:0] ridx_s1;
	logic          vld_q [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			raw_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				vld_q[i] <= 1'b0;
			end
			rvld_s1 <= 1'b0;
			ridx_s1 <= '0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_s1 <= vld_q[raddr];
				ridx_s1 <= raddr;
			end
		end
	end

	// An entry never written reads as its reset contents: slot zero busy, the rest stopped.
	always_comb begin
		if (rvld_s1) begin
			rdata = raw_s1;
		end else begin
			rdata        = '0;
			rdata.status = (ridx_s1 == '0) ? RST_CODE_BUSY : RST_CODE_STOPPED;
		end
	end

	assign ridx = ridx_s1;

endmodule

@@ src/server_slot_allocator_unit.sv @@
// Top level of the server slot allocator: control sequencer, registers and output stage.
//
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    cmd, now_ms, report_port, report_status,
//                                            report_pid, client_ip
// out      source     out_valid / out_ready  kind, slot, worker_port, second_port,
//                                            third_port, spawned, victim_pid, last
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A status report passes a range check, a read of the slot and a write back before its
// result; a port out of range is answered after the range check. A client request or a
// tick sweeps the slot memory through its single read port, one entry a cycle while no
// tick expiry stalls on the output; a request then reads its chosen slot once more before
// writing it. Reset clears the control state and the valid bits of the table at once;
// there is no clearing pass. A stalled output holds a tick's sweep in place without losing
// any entry.
module server_slot_allocator_unit
	import ssa_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [31:0] now_ms,
	input  logic [15:0] report_port,
	input  logic [7:0]  report_status,
	input  logic [31:0] report_pid,
	input  logic [31:0] client_ip,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [2:0]  slot,
	output logic [15:0] worker_port,
	output logic [15:0] second_port,
	output logic [15:0] third_port,
	output logic        spawned,
	output logic [31:0] victim_pid,
	output logic        last,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = IW + 1;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_SCAN     = 7'b0000010,
		S_RPT_CHK  = 7'b0000100,
		S_RPT_WR   = 7'b0001000,
		S_REQ_PICK = 7'b0010000,
		S_REQ_WR   = 7'b0100000,
		S_TICK_END = 7'b1000000
	} state_t;

	state_t state_q, state_nxt;

	// Configuration registers.
	logic [15:0] base_port_q, disk_port_q, keyboard_port_q;
	logic [31:0] timeout_q;
	logic [7:0]  code_stopped_q, code_free_q, code_busy_q;

	// The accepted transaction.
	logic [1:0]  cmd_q;
	logic [31:0] now_q, pid_q, ip_q;
	logic [15:0] port_q;
	logic [7:0]  status_q;

	// Sweep bookkeeping.
	logic [CW-1:0]    rd_idx_q;
	logic             s1_vld_q;
	logic             own_f_q, fre_f_q, stp_f_q;
	logic [IW-1:0]    own_i_q, fre_i_q, stp_i_q;
	logic             spawn_q;
	logic [IW-1:0]    use_q;
	logic             pend_vld_q;
	result_t          pend_q;
	logic [CNT_W-1:0] tcnt_q;

	// Output register.
	logic    out_valid_q;
	result_t out_q;

	// Memory access.
	logic          mem_re, mem_we;
	logic [IW-1:0] mem_raddr, mem_waddr, mem_ridx;
	slot_entry_t   mem_wdata, eff;

	logic          in_acc, out_free, is_tick, rd_done;
	logic          t_exp, stall, adv, tick_hit, req_proc;
	logic [16:0]   rpt_diff;
	logic          rpt_bad;
	logic [IW-1:0] rpt_idx, pick_idx;
	logic          push;
	result_t       push_res, hit_res;

	ssa_slot_mem #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.rdata  (eff),
		.ridx   (mem_ridx)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign is_tick   = (cmd_q == CMD_TICK);
	assign rd_done   = (rd_idx_q == CW'(SLOTS));

	// A report names a slot by its offset from the base port.
	assign rpt_diff = {1'b0, port_q} - {1'b0, base_port_q};
	assign rpt_bad  = rpt_diff[16] || (rpt_diff >= 17'(SLOTS));
	assign rpt_idx  = rpt_diff[IW-1:0];

	// An entry in the read stage of a tick sweep that has outlived the timeout.
	assign t_exp = (state_q == S_SCAN) && is_tick && s1_vld_q
		&& (eff.status != code_stopped_q) && ((now_q - eff.seen) > timeout_q);

	// A new expiry must first pass the one held back on to the output register.
	assign stall    = t_exp && pend_vld_q && !out_free;
	assign adv      = !stall;
	assign tick_hit = t_exp && adv;
	assign req_proc = (state_q == S_SCAN) && !is_tick && s1_vld_q;

	assign pick_idx = own_f_q ? own_i_q : (fre_f_q ? fre_i_q : stp_i_q);

	always_comb begin
		hit_res            = '0;
		hit_res.slot       = 3'(mem_ridx);
		if (eff.pid != '0) begin
			hit_res.kind       = KIND_RESTART;
			hit_res.victim_pid = eff.pid;
		end else begin
			hit_res.kind       = KIND_CLEARED;
		end
	end

	always_comb begin
		state_nxt = state_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		push      = 1'b0;
		push_res  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (cmd) inside
						CMD_REPORT:            state_nxt = S_RPT_CHK;
						CMD_REQUEST, CMD_TICK: state_nxt = S_SCAN;
						default:               state_nxt = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				mem_raddr = rd_idx_q[IW-1:0];
				mem_re    = adv && !rd_done;
				if (tick_hit) begin
					mem_we           = 1'b1;
					mem_waddr        = mem_ridx;
					mem_wdata.status = code_stopped_q;
				end
				if (t_exp && pend_vld_q && out_free) begin
					push     = 1'b1;
					push_res = pend_q;
				end
				if (tick_hit && (tcnt_q == CNT_W'(MAX_RESULTS - 1))) begin
					state_nxt = S_TICK_END;
				end else if (rd_done && (!s1_vld_q || adv)) begin
					state_nxt = is_tick ? S_TICK_END : S_REQ_PICK;
				end
			end
			S_RPT_CHK: begin
				if (rpt_bad) begin
					if (out_free) begin
						push          = 1'b1;
						push_res.kind = KIND_IGNORED;
						push_res.last = 1'b1;
						state_nxt     = S_IDLE;
					end
				end else begin
					mem_re    = 1'b1;
					mem_raddr = rpt_idx;
					state_nxt = S_RPT_WR;
				end
			end
			S_RPT_WR: begin
				if (out_free) begin
					// The owner is kept; everything else comes from the report.
					mem_we           = 1'b1;
					mem_waddr        = rpt_idx;
					mem_wdata.status = status_q;
					mem_wdata.owner  = eff.owner;
					mem_wdata.seen   = now_q;
					mem_wdata.pid    = pid_q;
					push             = 1'b1;
					push_res.kind    = KIND_STORED;
					push_res.slot    = 3'(rpt_idx);
					push_res.last    = 1'b1;
					state_nxt        = S_IDLE;
				end
			end
			S_REQ_PICK: begin
				if (own_f_q || fre_f_q || stp_f_q) begin
					mem_re    = 1'b1;
					mem_raddr = pick_idx;
					state_nxt = S_REQ_WR;
				end else if (out_free) begin
					push          = 1'b1;
					push_res.kind = KIND_REFUSED;
					push_res.last = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			S_REQ_WR: begin
				if (out_free) begin
					mem_we               = 1'b1;
					mem_waddr            = use_q;
					mem_wdata            = eff;
					mem_wdata.owner      = ip_q;
					if (spawn_q) begin
						mem_wdata.status = code_busy_q;
					end
					push                 = 1'b1;
					push_res.kind        = KIND_GRANTED;
					push_res.slot        = 3'(use_q);
					push_res.worker_port = base_port_q + 16'(use_q);
					push_res.second_port = disk_port_q;
					push_res.third_port  = keyboard_port_q;
					push_res.spawned     = spawn_q;
					push_res.last        = 1'b1;
					state_nxt            = S_IDLE;
				end
			end
			S_TICK_END: begin
				if (out_free) begin
					push = 1'b1;
					if (pend_vld_q) begin
						push_res = pend_q;
					end else begin
						push_res.kind = KIND_TICK_IDLE;
					end
					push_res.last = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			base_port_q     <= '0;
			disk_port_q     <= '0;
			keyboard_port_q <= '0;
			timeout_q       <= RST_TIMEOUT_MS;
			code_stopped_q  <= RST_CODE_STOPPED;
			code_free_q     <= RST_CODE_FREE;
			code_busy_q     <= RST_CODE_BUSY;
			rd_idx_q        <= '0;
			s1_vld_q        <= 1'b0;
			own_f_q         <= 1'b0;
			fre_f_q         <= 1'b0;
			stp_f_q         <= 1'b0;
			pend_vld_q      <= 1'b0;
			tcnt_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_BASE_PORT:     base_port_q     <= cfg_data[15:0];
					REG_DISK_PORT:     disk_port_q     <= cfg_data[15:0];
					REG_KEYBOARD_PORT: keyboard_port_q <= cfg_data[15:0];
					REG_TIMEOUT_MS:    timeout_q       <= cfg_data;
					REG_CODE_STOPPED:  code_stopped_q  <= cfg_data[7:0];
					REG_CODE_FREE:     code_free_q     <= cfg_data[7:0];
					REG_CODE_BUSY:     code_busy_q     <= cfg_data[7:0];
					default: ;
				endcase
			end

			if (state_q == S_IDLE) begin
				rd_idx_q   <= '0;
				s1_vld_q   <= 1'b0;
				own_f_q    <= 1'b0;
				fre_f_q    <= 1'b0;
				stp_f_q    <= 1'b0;
				pend_vld_q <= 1'b0;
				tcnt_q     <= '0;
			end else if (state_q == S_SCAN) begin
				if (mem_re) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (adv) begin
					s1_vld_q <= mem_re;
				end
				if (tick_hit) begin
					pend_vld_q <= 1'b1;
					tcnt_q     <= tcnt_q + CNT_W'(1);
				end
				// First owner match, first free slot and first stopped slot, in slot order.
				if (req_proc) begin
					if (!own_f_q && (eff.owner == ip_q)) begin
						own_f_q <= 1'b1;
					end
					if (!fre_f_q && (eff.status == code_free_q)) begin
						fre_f_q <= 1'b1;
					end
					if (!stp_f_q && (eff.status == code_stopped_q)) begin
						stp_f_q <= 1'b1;
					end
				end
			end else begin
				s1_vld_q <= 1'b0;
				// The held-back tick result is gone once the final one has been pushed.
				if (push) begin
					pend_vld_q <= 1'b0;
				end
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= cmd;
			now_q    <= now_ms;
			port_q   <= report_port;
			status_q <= report_status;
			pid_q    <= report_pid;
			ip_q     <= client_ip;
		end
		if (req_proc) begin
			if (!own_f_q) begin
				own_i_q <= mem_ridx;
			end
			if (!fre_f_q) begin
				fre_i_q <= mem_ridx;
			end
			if (!stp_f_q) begin
				stp_i_q <= mem_ridx;
			end
		end
		if (state_q == S_REQ_PICK) begin
			use_q   <= pick_idx;
			spawn_q <= !own_f_q && !fre_f_q;
		end
		if (tick_hit) begin
			pend_q <= hit_res;
		end
		if (push) begin
			out_q <= push_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign slot        = out_q.slot;
	assign worker_port = out_q.worker_port;
	assign second_port = out_q.second_port;
	assign third_port  = out_q.third_port;
	assign spawned     = out_q.spawned;
	assign victim_pid  = out_q.victim_pid;
	assign last        = out_q.last;

`ifndef ASSERT_OFF
	// The table is only written while a transaction is being worked on.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("slot table written while idle");

	// A tick never reports more slots than its result limit.
	a_tick_limit: assert property (@(posedge clk) disable iff (!arst_n)
		tcnt_q <= CNT_W'(MAX_RESULTS))
		else $error("tick result count beyond limit");

	// A held-back tick result exists only during a tick sweep or its final stage.
	a_pend_scope: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> ((state_q == S_SCAN) || (state_q == S_TICK_END)))
		else $error("pending tick result outside a tick");

	// A report transaction always starts with its range check.
	a_report_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (cmd == CMD_REPORT)) |=> (state_q == S_RPT_CHK))
		else $error("report did not enter its range check");
`endif

endmodule
